>>> design/websocket_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// websocket_frame_receiver_macros
// Assertion helpers shared by the deframer modules.
// ----------------------------------------------------------------------------
// Each expects clk_i and rst_ni in scope.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define WSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after the premise
`define WSFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the WebSocket frame receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

  // Header parse phases
  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_HALT    = 3'd6
  } phase_e;

  // Frame opcodes
  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  // Second header byte length escapes
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [63:0] CtrlMaxLen = 64'd125;

  // Result kinds
  localparam logic [1:0] KindApp   = 2'd0;
  localparam logic [1:0] KindReply = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // Payload formats
  localparam logic [1:0] FmtNone   = 2'd0;
  localparam logic [1:0] FmtText   = 2'd1;
  localparam logic [1:0] FmtBinary = 2'd2;

  // Error codes
  localparam logic [2:0] ErrOrphanCont = 3'd0;
  localparam logic [2:0] ErrResData    = 3'd1;
  localparam logic [2:0] ErrFragCtrl   = 3'd2;
  localparam logic [2:0] ErrCtrlLong   = 3'd3;
  localparam logic [2:0] ErrResCtrl    = 3'd4;

  // Fin bit or'd into a reply header byte
  localparam logic [7:0] FinBit = 8'h80;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] fmt;
    logic       frame_end;
    logic [2:0] err;
    logic       run_last;
  } res_t;

  // What one input byte causes: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } act_t;

endpackage

`default_nettype wire

>>> design/wsfr_parser.sv
// ----------------------------------------------------------------------------
// wsfr_parser
// Front end: walks the frame header, unmasks payload and builds the result
// group, if any, for each accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfr_parser
  import wsfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            act_valid_o,
  output act_t            act_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  op_q, op_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  key_q [4];
  logic [7:0]  key_d [4];
  logic [1:0]  fmt_q, fmt_d;
  logic        echo_q, echo_d;

  logic        hdr_done;
  logic        fail;
  logic [2:0]  fail_code;
  logic        emit_hdr;
  logic [3:0]  reply_op;
  logic [7:0]  pay_byte;
  logic        pay_end;
  logic [2:0]  len_last;

  // Next state and result group
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    fin_d       = fin_q;
    mask_d      = mask_q;
    len_d       = len_q;
    pos_d       = pos_q;
    key_d       = key_q;
    fmt_d       = fmt_q;
    echo_d      = echo_q;
    hdr_done    = 1'b0;
    fail        = 1'b0;
    fail_code   = ErrOrphanCont;
    emit_hdr    = 1'b0;
    reply_op    = OpPong;
    act_valid_o = 1'b0;
    act_o       = '0;
    pay_byte    = byte_i ^ (mask_q ? key_q[pos_q] : 8'h00);
    pay_end     = (len_q == 64'd1);
    len_last    = (phase_q == PH_LEN16) ? 3'd1 : 3'd7;

    case (phase_q)
      PH_HDR1: begin
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        phase_d = PH_HDR2;
      end
      PH_HDR2: begin
        mask_d = byte_i[7];
        cnt_d  = 3'd0;
        if (byte_i[6:0] == Len16Code) begin
          len_d   = '0;
          phase_d = PH_LEN16;
        end else if (byte_i[6:0] == Len64Code) begin
          len_d   = '0;
          phase_d = PH_LEN64;
        end else begin
          len_d = {57'd0, byte_i[6:0]};
          if (byte_i[7]) phase_d = PH_MASK;
          else hdr_done = 1'b1;
        end
      end
      PH_LEN16, PH_LEN64: begin
        // big-endian length, one byte at a time
        len_d = {len_q[55:0], byte_i};
        if (cnt_q >= len_last) begin
          cnt_d = 3'd0;
          if (mask_q) phase_d = PH_MASK;
          else hdr_done = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_MASK: begin
        key_d[cnt_q[1:0]] = byte_i;
        if (cnt_q >= 3'd3) begin
          cnt_d    = 3'd0;
          hdr_done = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        // len_q counts the bytes still to come
        pos_d = pos_q + 2'd1;
        len_d = len_q - 64'd1;
        if (!op_q[3]) begin
          act_valid_o = 1'b1;
          act_o.r0    = '{kind: KindApp, data: pay_byte, fmt: fmt_q,
                          frame_end: pay_end, err: ErrOrphanCont, run_last: 1'b1};
        end else if (echo_q) begin
          act_valid_o = 1'b1;
          act_o.r0    = '{kind: KindReply, data: pay_byte, fmt: FmtNone,
                          frame_end: pay_end, err: ErrOrphanCont, run_last: 1'b1};
        end
        if (pay_end) phase_d = PH_HDR1;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase

    // Header complete: check the frame and set up the payload
    if (hdr_done) begin
      pos_d  = 2'd0;
      echo_d = 1'b0;
      if (!op_q[3]) begin
        if (op_q == OpCont) begin
          if (fmt_q == FmtNone) begin
            fail      = 1'b1;
            fail_code = ErrOrphanCont;
          end
        end else if (op_q == OpText) begin
          fmt_d = FmtText;
        end else if (op_q == OpBinary) begin
          fmt_d = FmtBinary;
        end else begin
          fail      = 1'b1;
          fail_code = ErrResData;
        end
      end else if (!fin_q) begin
        fail      = 1'b1;
        fail_code = ErrFragCtrl;
      end else if (len_d > CtrlMaxLen) begin
        fail      = 1'b1;
        fail_code = ErrCtrlLong;
      end else if (op_q == OpClose) begin
        // a close without a status code gets no reply
        echo_d   = (len_d >= 64'd2);
        emit_hdr = (len_d >= 64'd2);
        reply_op = OpClose;
      end else if (op_q == OpPing) begin
        echo_d   = 1'b1;
        emit_hdr = 1'b1;
        reply_op = OpPong;
      end else if (op_q != OpPong) begin
        fail      = 1'b1;
        fail_code = ErrResCtrl;
      end

      if (fail) begin
        phase_d     = PH_HALT;
        act_valid_o = 1'b1;
        act_o.two   = 1'b0;
        act_o.r0    = '{kind: KindError, data: 8'h00, fmt: FmtNone,
                        frame_end: 1'b0, err: fail_code, run_last: 1'b1};
      end else begin
        phase_d = (len_d == 64'd0) ? PH_HDR1 : PH_PAYLOAD;
        if (emit_hdr) begin
          act_valid_o = 1'b1;
          act_o.two   = 1'b1;
          act_o.r0    = '{kind: KindReply, data: FinBit | {4'h0, reply_op}, fmt: FmtNone,
                          frame_end: 1'b0, err: ErrOrphanCont, run_last: 1'b0};
          act_o.r1    = '{kind: KindReply, data: len_d[7:0], fmt: FmtNone,
                          frame_end: (len_d == 64'd0), err: ErrOrphanCont,
                          run_last: 1'b1};
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR1;
      cnt_q   <= '0;
      op_q    <= '0;
      fin_q   <= 1'b0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      pos_q   <= '0;
      fmt_q   <= FmtNone;
      echo_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      fmt_q   <= fmt_d;
      echo_q  <= echo_d;
    end
  end

  // Mask key bytes
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      key_q <= key_d;
    end
  end

endmodule

`default_nettype wire

>>> design/wsfr_queue.sv
// ----------------------------------------------------------------------------
// wsfr_queue
// Short FIFO of result groups between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfr_queue
  import wsfr_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  act_t      wr_data_i,
  input  wire logic rd_i,
  output act_t      rd_data_o,
  output logic      full_o,
  output logic      empty_o
);

`include "websocket_frame_receiver_macros.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  act_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) count_q <= count_q + 1'b1;
      else if (rd_i && !wr_i) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `WSFR_ASSERT(a_no_overflow, !(wr_i && full_o && !rd_i), "queue written while full")
  `WSFR_ASSERT(a_no_underflow, !(rd_i && empty_o), "queue read while empty")
  `WSFR_ASSERT_NEXT(a_fill_up, wr_i && !rd_i, count_q == $past(count_q) + 1'b1, "fill level lost an item")

endmodule

`default_nettype wire

>>> design/wsfr_emitter.sv
// ----------------------------------------------------------------------------
// wsfr_emitter
// Back end: unpacks result groups into single items on the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfr_emitter
  import wsfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  act_t      q_data_i,
  output logic      q_rd_o,
  input  wire logic pop_i,
  output logic      out_valid_o,
  output res_t      out_o
);

`include "websocket_frame_receiver_macros.svh"

  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;
  logic sec_valid_q, sec_valid_d;
  res_t sec_q, sec_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || pop_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Refill the output register: second item first, then the next group
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sec_valid_d = sec_valid_q;
    sec_d       = sec_q;
    q_rd_o      = 1'b0;
    if (slot_free) begin
      if (sec_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = sec_q;
        sec_valid_d = 1'b0;
      end else if (!q_empty_i) begin
        q_rd_o      = 1'b1;
        out_valid_d = 1'b1;
        out_d       = q_data_i.r0;
        sec_valid_d = q_data_i.two;
        sec_d       = q_data_i.r1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_valid_q <= sec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  `WSFR_ASSERT(a_sec_behind_out, !sec_valid_q || out_valid_q, "second item staged without first")
  `WSFR_ASSERT(a_no_read_pending, !(sec_valid_q && q_rd_o), "group read while second item waits")
  `WSFR_ASSERT(a_partner_ready, !(out_valid_q && !out_q.run_last) || sec_valid_q, "non-final item without partner")

endmodule

`default_nettype wire

>>> design/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// RFC 6455 frame deframer: unmasks data payload and echoes ping and close.
// ----------------------------------------------------------------------------
//  Channel  | Handshake        | Signals
//  ---------+------------------+--------------------------------------------
//  input    | push / full      | rx_byte_i
//  result   | empty / pop      | out_kind_o out_byte_o payload_format_o
//           |                  | frame_end_o error_code_o run_last_o
//
//  One byte is taken per cycle while full is low; the parser updates its
//  header state in the cycle it takes the byte, and a result reaches the
//  result ports through the group queue and then the emitter output register.
//  A reply header gives two items from one byte, which the emitter sends one
//  after the other; the group queue (QueueDepth entries) absorbs the difference.
//  full rises when the group queue is full, so a stalled consumer backs up
//  to the input. Reset takes effect at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      payload_format_o,
  output logic            frame_end_o,
  output logic [2:0]      error_code_o,
  output logic            run_last_o
);

  logic accept;
  logic act_valid;
  act_t act;
  act_t q_data;
  logic q_full, q_empty, q_rd;
  logic out_valid;
  res_t res;

  assign full   = q_full;
  assign accept = push && !q_full;

  wsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .byte_i      (rx_byte_i),
    .act_valid_o (act_valid),
    .act_o       (act)
  );

  wsfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && act_valid),
    .wr_data_i (act),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  wsfr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  // Result ports
  assign empty            = !out_valid;
  assign out_kind_o       = res.kind;
  assign out_byte_o       = res.data;
  assign payload_format_o = res.fmt;
  assign frame_end_o      = res.frame_end;
  assign error_code_o     = res.err;
  assign run_last_o       = res.run_last;

endmodule

`default_nettype wire
